[hw/rtl/mtsf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtsf_pkg
// Shared types and constants of the mfm track sector finder.
// ----------------------------------------------------------------------------
package mtsf_pkg;

    // defaults for the top-level parameters
    localparam int MAX_SECTORS_DEF   = 32;
    localparam int POSITION_BITS_DEF = 13;

    // configuration port
    localparam int CFG_IW = 1;
    localparam int CFG_DW = 13;
    localparam logic [CFG_IW-1:0] CFG_TRACK_LENGTH = 1'd0;
    localparam logic [CFG_IW-1:0] CFG_DATA_WINDOW  = 1'd1;
    localparam logic [12:0] TRACK_LENGTH_RST = 13'd6250;
    localparam logic [5:0]  DATA_WINDOW_RST  = 6'd43;

    // address mark bytes
    localparam logic [7:0] MARK_SYNC    = 8'ha1;
    localparam logic [7:0] MARK_ID      = 8'hfe;
    localparam logic [7:0] MARK_DATA    = 8'hfb;
    localparam logic [7:0] MARK_DELETED = 8'hf8;

    // distances from the sync byte
    localparam int ID_FIELD_GAP  = 2;
    localparam int ID_SKIP       = 8;
    localparam int DATA_MIN_GAP  = 6;
    localparam int SCAN_TAIL     = 8;

    // result queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // payload widths
    localparam int OUT_DW = 40;

    typedef enum logic [1:0] {
        MODE_FIND_ID   = 2'd0,
        MODE_FIND_DATA = 2'd1
    } t_scan_mode;

    typedef enum logic {
        KIND_SECTOR = 1'b0,
        KIND_DONE   = 1'b1
    } t_result_kind;

    typedef struct packed {
        t_result_kind kind;
        logic [4:0]   sector_slot;
        logic [12:0]  id_offset;
        logic         data_found;
        logic [12:0]  data_offset;
        logic         deleted_mark;
        logic [5:0]   sector_total;
        logic         table_overflow;
        logic         last_result;
    } t_result;

    typedef struct packed {
        logic [1:0] cnt;
        t_result    rec0;
        t_result    rec1;
    } t_push;

endpackage
`default_nettype wire

[hw/rtl/mtsf_scan.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtsf_scan
// Input register, configuration registers and the address mark scanner.
// One registered byte is judged per cycle, while the result queue has room, against the held previous byte.
// ----------------------------------------------------------------------------
module mtsf_scan import mtsf_pkg::*; #(
    parameter int MAX_SECTORS   = MAX_SECTORS_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_IW-1:0] i_cfg_index,
    input  wire logic [CFG_DW-1:0] i_cfg_data,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [7:0]        i_byte,
    input  wire logic              i_mark,
    input  wire logic              i_eot,
    input  wire logic              i_room,
    output t_push                  o_push
);

    localparam int PB = POSITION_BITS;
    localparam int CW = ((PB > 13) ? PB : 13) + 1;
    localparam int SW = $clog2(MAX_SECTORS + 1);
    localparam logic [PB-1:0] POS_SAT = {PB{1'b1}};

    // configuration
    logic [12:0] r_track_length;
    logic [5:0]  r_data_window;

    // input register
    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_mark;
    logic       r_eot;

    // scan state
    t_scan_mode    r_mode,    n_mode;
    logic [PB-1:0] r_pos,     n_pos;
    logic [7:0]    r_held,    n_held;
    logic          r_held_mk, n_held_mk;
    logic          r_held_vd, n_held_vd;
    logic [CW-1:0] r_plim,    n_plim;
    logic [PB-1:0] r_pend,    n_pend;
    logic [SW-1:0] r_seen,    n_seen;
    logic          r_ovf,     n_ovf;

    logic          advance;
    logic          scan_ok;
    logic [PB-1:0] idx;
    logic [CW-1:0] idx_w;
    logic [12:0]   limit;
    logic [CW-1:0] limit_w;
    logic [CW-1:0] win_end;
    logic          sync_held;
    logic          data_end;
    logic          data_mark;
    logic          sector_hit;
    logic          emit;
    logic          id_hit;
    logic          found;
    t_scan_mode    mode_mid;
    logic [SW-1:0] seen_mid;
    logic          ovf_mid;
    t_result       sec_rec;
    t_result       done_rec;

    assign advance = r_in_valid && i_room;
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track_length <= TRACK_LENGTH_RST;
            r_data_window  <= DATA_WINDOW_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TRACK_LENGTH: r_track_length <= i_cfg_data[12:0];
                CFG_DATA_WINDOW:  r_data_window  <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
            r_mark <= i_mark;
            r_eot  <= i_eot;
        end
    end

    // decision logic
    always_comb begin
        scan_ok   = advance && (r_pos != POS_SAT) && r_held_vd;
        idx       = r_pos - PB'(1);
        idx_w     = CW'(idx);
        limit     = (r_track_length >= 13'(SCAN_TAIL)) ?
                    (r_track_length - 13'(SCAN_TAIL)) : 13'd0;
        limit_w   = CW'(limit);
        win_end   = idx_w + CW'(ID_SKIP) + CW'(r_data_window);
        sync_held = (r_held == MARK_SYNC) && r_held_mk;
        data_end  = scan_ok && (r_mode == MODE_FIND_DATA) && (idx_w >= r_plim);
        data_mark = scan_ok && (r_mode == MODE_FIND_DATA) && !data_end
                    && (idx_w >= CW'(r_pend) + CW'(DATA_MIN_GAP))
                    && sync_held && !r_mark;
        sector_hit = data_end || data_mark;
        mode_mid   = sector_hit ? MODE_FIND_ID : r_mode;
        // the pair that closes a data search may open the next sector
        id_hit     = scan_ok && (mode_mid == MODE_FIND_ID) && (idx_w < limit_w)
                     && sync_held && (r_byte == MARK_ID);
        emit       = sector_hit && (r_seen < SW'(MAX_SECTORS));
        found      = data_mark && ((r_byte == MARK_DATA) || (r_byte == MARK_DELETED));
        seen_mid   = emit ? (r_seen + SW'(1)) : r_seen;
        ovf_mid    = r_ovf || (sector_hit && !emit);
    end

    // next state
    always_comb begin
        n_mode    = mode_mid;
        n_pos     = r_pos;
        n_held    = r_held;
        n_held_mk = r_held_mk;
        n_held_vd = r_held_vd;
        n_plim    = r_plim;
        n_pend    = r_pend;
        n_seen    = seen_mid;
        n_ovf     = ovf_mid;
        if (advance && (r_pos != POS_SAT)) begin
            n_held    = r_byte;
            n_held_mk = r_mark;
            n_held_vd = 1'b1;
            n_pos     = r_pos + PB'(1);
        end
        if (id_hit) begin
            n_pend = idx + PB'(ID_FIELD_GAP);
            n_plim = (win_end < limit_w) ? win_end : limit_w;
            n_mode = MODE_FIND_DATA;
        end
        if (advance && r_eot) begin
            n_mode    = MODE_FIND_ID;
            n_pos     = '0;
            n_held    = '0;
            n_held_mk = 1'b0;
            n_held_vd = 1'b0;
            n_plim    = '0;
            n_pend    = '0;
            n_seen    = '0;
            n_ovf     = 1'b0;
        end
    end

    // result records
    always_comb begin
        sec_rec                = '0;
        sec_rec.kind           = KIND_SECTOR;
        sec_rec.sector_slot    = 5'(r_seen);
        sec_rec.id_offset      = 13'(r_pend);
        sec_rec.data_found     = found;
        sec_rec.data_offset    = found ? 13'(idx + PB'(ID_FIELD_GAP)) : 13'd0;
        sec_rec.deleted_mark   = found && (r_byte == MARK_DELETED);
        sec_rec.last_result    = !r_eot;

        done_rec                = '0;
        done_rec.kind           = KIND_DONE;
        done_rec.sector_total   = 6'(seen_mid);
        done_rec.table_overflow = ovf_mid;
        done_rec.last_result    = 1'b1;

        o_push      = '0;
        o_push.rec1 = done_rec;
        if (emit) begin
            o_push.rec0 = sec_rec;
            o_push.cnt  = (advance && r_eot) ? 2'd2 : 2'd1;
        end else begin
            o_push.rec0 = done_rec;
            o_push.cnt  = (advance && r_eot) ? 2'd1 : 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_FIND_ID;
            r_pos     <= '0;
            r_held    <= '0;
            r_held_mk <= 1'b0;
            r_held_vd <= 1'b0;
            r_plim    <= '0;
            r_pend    <= '0;
            r_seen    <= '0;
            r_ovf     <= 1'b0;
        end else begin
            r_mode    <= n_mode;
            r_pos     <= n_pos;
            r_held    <= n_held;
            r_held_mk <= n_held_mk;
            r_held_vd <= n_held_vd;
            r_plim    <= n_plim;
            r_pend    <= n_pend;
            r_seen    <= n_seen;
            r_ovf     <= n_ovf;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/mtsf_out_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtsf_out_queue
// Small result queue that takes up to two records a cycle and hands out one.
// ----------------------------------------------------------------------------
module mtsf_out_queue import mtsf_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_push i_push,
    output logic       o_room,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_result    o_rec
);

    t_result          r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_rd,    n_rd;
    logic [Q_AW-1:0]  r_wr,    n_wr;
    logic [Q_AW:0]    r_count, n_count;
    logic             pop;

    assign o_valid = (r_count != '0);
    assign pop     = o_valid && i_ready;
    assign o_rec   = r_mem[r_rd];
    // room for two records once this cycle's request leaves
    assign o_room  = (r_count - (Q_AW+1)'(pop)) <= (Q_AW+1)'(Q_DEPTH - 2);

    always_comb begin
        n_rd    = pop ? (r_rd + Q_AW'(1)) : r_rd;
        n_wr    = r_wr + Q_AW'(i_push.cnt);
        n_count = r_count + (Q_AW+1)'(i_push.cnt) - (Q_AW+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.rec0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wr + Q_AW'(1)] <= i_push.rec1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd    <= '0;
            r_wr    <= '0;
            r_count <= '0;
        end else begin
            r_rd    <= n_rd;
            r_wr    <= n_wr;
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/mfm_track_sector_finder.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfm_track_sector_finder
// Finds ID and data address marks in a raw mfm track byte stream and reports
// one record per sector (up to MAX_SECTORS) plus a count record at the end of the track.
//
// Slave stream: one raw track byte per request, marker bit in tuser, tlast on
// the final byte of the track. Master stream: sector records (tuser 0) and the
// track done record (tuser 1); tlast marks the last record caused by a byte.
// A byte is taken into the input register, judged there against the byte
// before it, and its records land in a four-entry result queue, from which
// they are offered. One byte is accepted every cycle while the queue has
// room; only a byte that yields both a sector record and the done record
// pushes two records. When the receiver stalls the queue fills and tready
// drops once fewer than two entries would be free. Reset restores the
// register defaults (6250 bytes, 43 byte window), empties the queue and
// returns the scanner to searching for an ID mark at position zero.
// Configuration writes take effect on the next clock edge.
// ----------------------------------------------------------------------------
module mfm_track_sector_finder import mtsf_pkg::*; #(
    parameter int MAX_SECTORS   = MAX_SECTORS_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_IW-1:0] i_cfg_index,
    input  wire logic [CFG_DW-1:0] i_cfg_data,
    input  wire logic              i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  wire logic [7:0]        i_s_axis_tdata,  // track_byte
    input  wire logic              i_s_axis_tuser,  // marker_bit
    input  wire logic              i_s_axis_tlast,  // end_of_track
    output logic                   o_m_axis_tvalid,
    input  wire logic              i_m_axis_tready,
    // sector_slot, id_offset, data_found, data_offset, deleted_mark,
    // sector_total, table_overflow
    output logic [OUT_DW-1:0]      o_m_axis_tdata,
    output logic                   o_m_axis_tuser,  // result_kind
    output logic                   o_m_axis_tlast   // last_result
);

    t_push   push;
    logic    room;
    t_result rec;

    mtsf_scan #(
        .MAX_SECTORS   (MAX_SECTORS),
        .POSITION_BITS (POSITION_BITS)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_byte      (i_s_axis_tdata),
        .i_mark      (i_s_axis_tuser),
        .i_eot       (i_s_axis_tlast),
        .i_room      (room),
        .o_push      (push)
    );

    mtsf_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_rec   (rec)
    );

    assign o_m_axis_tdata = {rec.table_overflow, rec.sector_total, rec.deleted_mark,
                             rec.data_offset, rec.data_found, rec.id_offset,
                             rec.sector_slot};
    assign o_m_axis_tuser = rec.kind;
    assign o_m_axis_tlast = rec.last_result;

endmodule
`default_nettype wire
